### sv/quaternion_rigid_transform_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros for the quaternion rigid transform
// Shorthand for clocked implication checks with a synchronous reset.
// ----------------------------------------------------------------------------
`ifndef QUATERNION_RIGID_TRANSFORM_MACROS_SVH
`define QUATERNION_RIGID_TRANSFORM_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define QRT_ASSERT_IMPLIES(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define QRT_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

### sv/qrt_pkg.sv
// ----------------------------------------------------------------------------
// qrt_pkg
// Widths, types, register indexes and rounding helpers shared by the
// quaternion rigid transform pipeline.
// ----------------------------------------------------------------------------
package qrt_pkg;

   localparam int COORD_W = 32;
   localparam int QUAT_W  = 16;
   localparam int QFRAC   = 14;

   // A quaternion component, negated for the inverse, needs one extra bit.
   localparam int AXIS_W  = QUAT_W + 1;
   // Widest operand of a cross product: the first cross product output.
   localparam int VEC_W   = COORD_W + 4;
   localparam int PROD_W  = AXIS_W + VEC_W;
   localparam int RND_W   = PROD_W - QFRAC;
   localparam int CROSS_W = RND_W + 1;
   localparam int SUM_W   = COORD_W + 16;

   localparam int STAGES  = 7;

   localparam int REG_IDX_W = 3;
   localparam logic [REG_IDX_W-1:0] REG_ROT_W   = 3'd0;
   localparam logic [REG_IDX_W-1:0] REG_ROT_X   = 3'd1;
   localparam logic [REG_IDX_W-1:0] REG_ROT_Y   = 3'd2;
   localparam logic [REG_IDX_W-1:0] REG_ROT_Z   = 3'd3;
   localparam logic [REG_IDX_W-1:0] REG_SHIFT_X = 3'd4;
   localparam logic [REG_IDX_W-1:0] REG_SHIFT_Y = 3'd5;
   localparam logic [REG_IDX_W-1:0] REG_SHIFT_Z = 3'd6;

   typedef logic signed [COORD_W-1:0] coord_type;
   typedef logic signed [QUAT_W-1:0]  quat_type;
   typedef logic signed [AXIS_W-1:0]  axis_type;
   typedef logic signed [VEC_W-1:0]   vec_type;
   typedef logic signed [PROD_W-1:0]  prod_type;
   typedef logic signed [RND_W-1:0]   rnd_type;
   typedef logic signed [CROSS_W-1:0] cross_type;
   typedef logic signed [SUM_W-1:0]   sum_type;

   localparam quat_type  ROT_ONE    = quat_type'(64'd1 << QFRAC);
   localparam prod_type  ROUND_HALF = prod_type'(64'd1 << (QFRAC - 1));
   localparam coord_type COORD_MAX  = {1'b0, {(COORD_W-1){1'b1}}};
   localparam coord_type COORD_MIN  = {1'b1, {(COORD_W-1){1'b0}}};

   // Load enables of the two register stages inside one pipeline unit.
   typedef struct packed {
      logic load_a;
      logic load_b;
   } stage_ctl_type;

   typedef struct packed {
      logic inv;
      logic dir;
   } item_flags_type;

   // Round half up, then drop the quaternion fraction bits.
   function automatic rnd_type round_q(prod_type p);
      prod_type t;
      t = p + ROUND_HALF;
      return t[PROD_W-1:QFRAC];
   endfunction

   function automatic axis_type axis_sel(quat_type a, logic negate);
      axis_type e;
      e = AXIS_W'(a);
      return negate ? -e : e;
   endfunction

endpackage

### sv/qrt_req_if.sv
// ----------------------------------------------------------------------------
// qrt_req_if
// Input channel: one coordinate and its mode bits per transfer.
// ----------------------------------------------------------------------------
interface qrt_req_if
   import qrt_pkg::*;
();
   logic      valid;
   logic      ready;
   coord_type in_x;
   coord_type in_y;
   coord_type in_z;
   logic      is_direction;
   logic      use_inverse;

   modport source (
      output valid, in_x, in_y, in_z, is_direction, use_inverse,
      input  ready
   );

   modport sink (
      input  valid, in_x, in_y, in_z, is_direction, use_inverse,
      output ready
   );
endinterface

### sv/qrt_rsp_if.sv
// ----------------------------------------------------------------------------
// qrt_rsp_if
// Result channel: one transformed coordinate and its saturation flag.
// ----------------------------------------------------------------------------
interface qrt_rsp_if
   import qrt_pkg::*;
();
   logic      valid;
   logic      ready;
   coord_type out_x;
   coord_type out_y;
   coord_type out_z;
   logic      clipped;

   modport source (
      output valid, out_x, out_y, out_z, clipped,
      input  ready
   );

   modport sink (
      input  valid, out_x, out_y, out_z, clipped,
      output ready
   );
endinterface

### sv/qrt_cross.sv
// ----------------------------------------------------------------------------
// qrt_cross
// Two-stage cross product u x b with every product rounded to coordinate
// scale on its own: products first, then rounding and subtraction.
// ----------------------------------------------------------------------------
module qrt_cross
   import qrt_pkg::*;
(
   input  logic          clock,
   input  stage_ctl_type ctl,
   input  axis_type      u [3],
   input  vec_type       b [3],
   output cross_type     c [3]
);

   prod_type  prod_in [6];
   prod_type  prod_ff [6];
   cross_type c_in [3];
   cross_type c_ff [3];

   always_comb begin
      prod_in[0] = PROD_W'(u[1]) * PROD_W'(b[2]);
      prod_in[1] = PROD_W'(u[2]) * PROD_W'(b[1]);
      prod_in[2] = PROD_W'(u[2]) * PROD_W'(b[0]);
      prod_in[3] = PROD_W'(u[0]) * PROD_W'(b[2]);
      prod_in[4] = PROD_W'(u[0]) * PROD_W'(b[1]);
      prod_in[5] = PROD_W'(u[1]) * PROD_W'(b[0]);
   end

   always_comb begin
      for (int i = 0; i < 3; i++) begin
         c_in[i] = CROSS_W'(round_q(prod_ff[2*i])) - CROSS_W'(round_q(prod_ff[2*i+1]));
      end
   end

   always_ff @(posedge clock) begin
      if (ctl.load_a) begin
         prod_ff <= prod_in;
      end
      if (ctl.load_b) begin
         c_ff <= c_in;
      end
   end

   assign c = c_ff;

endmodule

### sv/qrt_scale.sv
// ----------------------------------------------------------------------------
// qrt_scale
// Two-stage scaling of the first cross product by the quaternion scalar
// part, rounded to coordinate scale.
// ----------------------------------------------------------------------------
module qrt_scale
   import qrt_pkg::*;
(
   input  logic          clock,
   input  stage_ctl_type ctl,
   input  quat_type      w,
   input  vec_type       c [3],
   output rnd_type       m [3]
);

   prod_type prod_in [3];
   prod_type prod_ff [3];
   rnd_type  m_in [3];
   rnd_type  m_ff [3];

   always_comb begin
      for (int i = 0; i < 3; i++) begin
         prod_in[i] = PROD_W'(w) * PROD_W'(c[i]);
         m_in[i]    = round_q(prod_ff[i]);
      end
   end

   always_ff @(posedge clock) begin
      if (ctl.load_a) begin
         prod_ff <= prod_in;
      end
      if (ctl.load_b) begin
         m_ff <= m_in;
      end
   end

   assign m = m_ff;

endmodule

### sv/qrt_out.sv
// ----------------------------------------------------------------------------
// qrt_out
// Final sum v + 2m + 2d (+ translation for a forward point), then
// saturation to the coordinate range. The second stage is the result
// register seen on the output channel.
// ----------------------------------------------------------------------------
module qrt_out
   import qrt_pkg::*;
(
   input  logic          clock,
   input  stage_ctl_type ctl,
   input  vec_type       v [3],
   input  rnd_type       m [3],
   input  cross_type     d [3],
   input  coord_type     t [3],
   input  logic          add_t,
   output coord_type     r [3],
   output logic          clip
);

   localparam sum_type SAT_MAX = sum_type'(COORD_MAX);
   localparam sum_type SAT_MIN = sum_type'(COORD_MIN);

   coord_type t_add [3];
   sum_type   sum_in [3];
   sum_type   sum_ff [3];
   coord_type r_in [3];
   coord_type r_ff [3];
   logic      clip_in;
   logic      clip_ff;

   always_comb begin
      for (int i = 0; i < 3; i++) begin
         t_add[i]  = add_t ? t[i] : '0;
         sum_in[i] = SUM_W'(v[i]) + (SUM_W'(m[i]) <<< 1) + (SUM_W'(d[i]) <<< 1)
                   + SUM_W'(t_add[i]);
      end
   end

   always_comb begin
      clip_in = 1'b0;
      for (int i = 0; i < 3; i++) begin
         if (sum_ff[i] > SAT_MAX) begin
            r_in[i] = COORD_MAX;
            clip_in = 1'b1;
         end else if (sum_ff[i] < SAT_MIN) begin
            r_in[i] = COORD_MIN;
            clip_in = 1'b1;
         end else begin
            r_in[i] = sum_ff[i][COORD_W-1:0];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (ctl.load_a) begin
         sum_ff <= sum_in;
      end
      if (ctl.load_b) begin
         r_ff    <= r_in;
         clip_ff <= clip_in;
      end
   end

   assign r    = r_ff;
   assign clip = clip_ff;

endmodule

### sv/quaternion_rigid_transform.sv
// ----------------------------------------------------------------------------
// quaternion_rigid_transform
// Rotates a Q16.16 coordinate by a Q1.14 quaternion and translates it.
// ----------------------------------------------------------------------------
// The block takes one coordinate per clock, with a sustained rate of one item
// per cycle while the result side is ready; a stall there holds the input.
// Each result passes through every register stage in order and is presented
// on the output from the result register.
// The seven register stages are: input and translation subtract, the two
// stages of the first cross product, the two stages of the second cross
// product and the scalar scaling, the final sum, and saturation into the
// result register; the 17 x 36 bit multipliers set the clock period.
// Each stage moves when its successor has room, so bubbles fill up while
// the result side stalls. Quaternion and translation are read straight
// from the registers, so write them only while no item is in flight.
// ----------------------------------------------------------------------------
`include "quaternion_rigid_transform_macros.svh"

module quaternion_rigid_transform
   import qrt_pkg::*;
(
   input  logic                 clock,
   input  logic                 reset,
   qrt_req_if.sink              req_bus,
   qrt_rsp_if.source            rsp_bus,
   input  logic                 csr_wen,
   input  logic [REG_IDX_W-1:0] csr_index,
   input  logic [COORD_W-1:0]   csr_wdata
);

   quat_type       rot_ff [4];
   coord_type      shift_ff [3];

   logic [STAGES-1:0] valid_ff;
   logic [STAGES-1:0] valid_in;
   logic [STAGES-1:0] en;

   vec_type        vec_ff [5][3];
   item_flags_type flags_ff [5];
   vec_type        front_in [3];
   coord_type      req_coord [3];
   item_flags_type req_flags;

   axis_type       u_first [3];
   axis_type       u_second [3];
   cross_type      c_wide [3];
   vec_type        c_narrow [3];
   cross_type      d_val [3];
   rnd_type        m_val [3];
   coord_type      r_val [3];
   logic           clip_val;
   logic           add_t;
   logic           rsp_at_limit;

   stage_ctl_type  ctl_first;
   stage_ctl_type  ctl_second;
   stage_ctl_type  ctl_out;

   // Configuration registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         rot_ff[0]   <= ROT_ONE;
         rot_ff[1]   <= '0;
         rot_ff[2]   <= '0;
         rot_ff[3]   <= '0;
         shift_ff[0] <= '0;
         shift_ff[1] <= '0;
         shift_ff[2] <= '0;
      end else if (csr_wen) begin
         case (csr_index)
            REG_ROT_W:   rot_ff[0]   <= csr_wdata[QUAT_W-1:0];
            REG_ROT_X:   rot_ff[1]   <= csr_wdata[QUAT_W-1:0];
            REG_ROT_Y:   rot_ff[2]   <= csr_wdata[QUAT_W-1:0];
            REG_ROT_Z:   rot_ff[3]   <= csr_wdata[QUAT_W-1:0];
            REG_SHIFT_X: shift_ff[0] <= csr_wdata;
            REG_SHIFT_Y: shift_ff[1] <= csr_wdata;
            REG_SHIFT_Z: shift_ff[2] <= csr_wdata;
            default: begin
            end
         endcase
      end
   end

   // A stage may load when it is empty or its contents move on this cycle.
   always_comb begin
      en[STAGES-1] = !valid_ff[STAGES-1] || rsp_bus.ready;
      for (int k = STAGES - 2; k >= 0; k--) begin
         en[k] = !valid_ff[k] || en[k+1];
      end
      valid_in[0] = req_bus.valid;
      for (int k = 1; k < STAGES; k++) begin
         valid_in[k] = valid_ff[k-1];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else begin
         for (int k = 0; k < STAGES; k++) begin
            if (en[k]) begin
               valid_ff[k] <= valid_in[k];
            end
         end
      end
   end

   assign req_bus.ready = en[0];

   // Input stage: an inverse point has the translation removed first.
   always_comb begin
      req_coord[0]  = req_bus.in_x;
      req_coord[1]  = req_bus.in_y;
      req_coord[2]  = req_bus.in_z;
      req_flags.inv = req_bus.use_inverse;
      req_flags.dir = req_bus.is_direction;
      for (int i = 0; i < 3; i++) begin
         if (req_flags.inv && !req_flags.dir) begin
            front_in[i] = VEC_W'(req_coord[i]) - VEC_W'(shift_ff[i]);
         end else begin
            front_in[i] = VEC_W'(req_coord[i]);
         end
      end
   end

   // Coordinate and mode bits ride along until the final sum.
   always_ff @(posedge clock) begin
      if (en[0]) begin
         vec_ff[0]   <= front_in;
         flags_ff[0] <= req_flags;
      end
      for (int k = 1; k < 5; k++) begin
         if (en[k]) begin
            vec_ff[k]   <= vec_ff[k-1];
            flags_ff[k] <= flags_ff[k-1];
         end
      end
   end

   always_comb begin
      for (int i = 0; i < 3; i++) begin
         u_first[i]  = axis_sel(rot_ff[i+1], flags_ff[0].inv);
         u_second[i] = axis_sel(rot_ff[i+1], flags_ff[2].inv);
         c_narrow[i] = c_wide[i][VEC_W-1:0];
      end
      add_t = !flags_ff[4].inv && !flags_ff[4].dir;
      ctl_first.load_a  = en[1];
      ctl_first.load_b  = en[2];
      ctl_second.load_a = en[3];
      ctl_second.load_b = en[4];
      ctl_out.load_a    = en[5];
      ctl_out.load_b    = en[6];
   end

   qrt_cross u_cross_first (
      .clock (clock),
      .ctl   (ctl_first),
      .u     (u_first),
      .b     (vec_ff[0]),
      .c     (c_wide)
   );

   qrt_cross u_cross_second (
      .clock (clock),
      .ctl   (ctl_second),
      .u     (u_second),
      .b     (c_narrow),
      .c     (d_val)
   );

   qrt_scale u_scale (
      .clock (clock),
      .ctl   (ctl_second),
      .w     (rot_ff[0]),
      .c     (c_narrow),
      .m     (m_val)
   );

   qrt_out u_out (
      .clock (clock),
      .ctl   (ctl_out),
      .v     (vec_ff[4]),
      .m     (m_val),
      .d     (d_val),
      .t     (shift_ff),
      .add_t (add_t),
      .r     (r_val),
      .clip  (clip_val)
   );

   assign rsp_bus.valid   = valid_ff[STAGES-1];
   assign rsp_bus.out_x   = r_val[0];
   assign rsp_bus.out_y   = r_val[1];
   assign rsp_bus.out_z   = r_val[2];
   assign rsp_bus.clipped = clip_val;

   assign rsp_at_limit = rsp_bus.out_x == COORD_MAX || rsp_bus.out_x == COORD_MIN
                      || rsp_bus.out_y == COORD_MAX || rsp_bus.out_y == COORD_MIN
                      || rsp_bus.out_z == COORD_MAX || rsp_bus.out_z == COORD_MIN;

   `QRT_ASSERT_NEXT(a_transfer_enters_pipe, clock, reset, req_bus.valid && req_bus.ready,
      valid_ff[0], "accepted transfer did not enter the first stage")
   `QRT_ASSERT_IMPLIES(a_backpressure_only_when_full, clock, reset, !req_bus.ready,
      &valid_ff, "input stalled while a pipeline stage is empty")
   `QRT_ASSERT_IMPLIES(a_clip_means_limit, clock, reset, rsp_bus.valid && rsp_bus.clipped,
      rsp_at_limit, "clipped result has no component at a limit")

endmodule

### tb/quaternion_rigid_transform_tb.sv
// ----------------------------------------------------------------------------
// quaternion_rigid_transform_tb
// Self-checking bench for the quaternion rigid transform. A clocked driver
// feeds coordinates from a queue under random gaps, and a clocked monitor
// compares every result against a bit-exact fixed-point prediction under
// random back-pressure. The transform is reprogrammed between drained phases.
// ----------------------------------------------------------------------------
module quaternion_rigid_transform_tb;
   import qrt_pkg::*;

   localparam int SETTLE_CYCLES   = STAGES + 5;
   localparam int RANDOM_PHASES   = 6;
   localparam int ITEMS_PER_PHASE = 140;
   localparam int HOLD_CYCLES     = 150;
   localparam int LIMIT_CYCLES    = 250000;

   // Wide enough that no intermediate of the rotation can overflow.
   typedef logic signed [95:0] wide_type;

   typedef struct packed {
      wide_type x;
      wide_type y;
      wide_type z;
   } trio_type;

   typedef struct {
      coord_type x;
      coord_type y;
      coord_type z;
      logic      dir;
      logic      inv;
   } coord_item_type;

   typedef struct {
      coord_type x;
      coord_type y;
      coord_type z;
      logic      clipped;
   } transform_type;

   localparam wide_type HALF_LSB = wide_type'(1) <<< (QFRAC - 1);

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic                 csr_wen;
   logic [REG_IDX_W-1:0] csr_index;
   logic [COORD_W-1:0]   csr_wdata;

   qrt_req_if req_bus ();
   qrt_rsp_if rsp_bus ();

   quaternion_rigid_transform i_dut (
      .clock     (clock),
      .reset     (reset),
      .req_bus   (req_bus),
      .rsp_bus   (rsp_bus),
      .csr_wen   (csr_wen),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   always #10 clock = ~clock;

   // Shadow copy of the transform registers.
   quat_type  quat_w = ROT_ONE;
   quat_type  quat_x = '0;
   quat_type  quat_y = '0;
   quat_type  quat_z = '0;
   coord_type offset_x = '0;
   coord_type offset_y = '0;
   coord_type offset_z = '0;

   coord_item_type coords_to_send[$];
   transform_type  pending_transforms[$];

   int   mismatches      = 0;
   int   items_sent      = 0;
   int   results_checked = 0;
   int   results_clipped = 0;
   int   settings_used   = 1;
   logic hold_off        = 1'b0;

   // Exact product of a quaternion component and a coordinate, rounded
   // half up back to coordinate scale.
   function automatic wide_type qmul(wide_type a, wide_type b);
      return (a * b + HALF_LSB) >>> QFRAC;
   endfunction

   function automatic trio_type cross3(trio_type a, trio_type b);
      trio_type r;
      r.x = qmul(a.y, b.z) - qmul(a.z, b.y);
      r.y = qmul(a.z, b.x) - qmul(a.x, b.z);
      r.z = qmul(a.x, b.y) - qmul(a.y, b.x);
      return r;
   endfunction

   function automatic coord_type clamp(wide_type val, inout logic clip);
      if (val > wide_type'(COORD_MAX)) begin
         clip = 1'b1;
         return COORD_MAX;
      end
      if (val < wide_type'(COORD_MIN)) begin
         clip = 1'b1;
         return COORD_MIN;
      end
      return coord_type'(val);
   endfunction

   function automatic transform_type rigid_transform(coord_type px, coord_type py,
                                                     coord_type pz, logic dir, logic inv);
      trio_type      v, u, c, d, r, t;
      wide_type      w;
      transform_type res;
      logic          clip;
      v.x = px;
      v.y = py;
      v.z = pz;
      u.x = quat_x;
      u.y = quat_y;
      u.z = quat_z;
      t.x = offset_x;
      t.y = offset_y;
      t.z = offset_z;
      w   = quat_w;
      if (inv) begin
         u.x = -u.x;
         u.y = -u.y;
         u.z = -u.z;
         // The difference stays exact, one bit wider than a coordinate.
         if (!dir) begin
            v.x = v.x - t.x;
            v.y = v.y - t.y;
            v.z = v.z - t.z;
         end
      end
      c = cross3(u, v);
      d = cross3(u, c);
      r.x = v.x + 2 * qmul(w, c.x) + 2 * d.x;
      r.y = v.y + 2 * qmul(w, c.y) + 2 * d.y;
      r.z = v.z + 2 * qmul(w, c.z) + 2 * d.z;
      if (!inv && !dir) begin
         r.x = r.x + t.x;
         r.y = r.y + t.y;
         r.z = r.z + t.z;
      end
      clip = 1'b0;
      res.x = clamp(r.x, clip);
      res.y = clamp(r.y, clip);
      res.z = clamp(r.z, clip);
      res.clipped = clip;
      return res;
   endfunction

   function automatic coord_type rand_coord();
      int pick;
      pick = $urandom_range(0, 9);
      if (pick < 4)
         return coord_type'(int'($urandom_range(0, 2097152)) - 1048576);
      if (pick == 4) begin
         case ($urandom_range(0, 3))
            0: return COORD_MAX;
            1: return COORD_MIN;
            2: return '0;
            default: return '1;
         endcase
      end
      return coord_type'($urandom);
   endfunction

   task automatic queue_item(coord_type x, coord_type y, coord_type z, logic dir, logic inv);
      coord_item_type item;
      item.x = x;
      item.y = y;
      item.z = z;
      item.dir = dir;
      item.inv = inv;
      coords_to_send.push_back(item);
   endtask

   task automatic write_reg(logic [REG_IDX_W-1:0] index, logic [COORD_W-1:0] data);
      @(posedge clock);
      csr_wen   <= 1'b1;
      csr_index <= index;
      csr_wdata <= data;
      @(posedge clock);
      csr_wen   <= 1'b0;
   endtask

   task automatic set_transform(quat_type w, quat_type x, quat_type y, quat_type z,
                                coord_type sx, coord_type sy, coord_type sz);
      write_reg(REG_ROT_W, coord_type'(w));
      write_reg(REG_ROT_X, coord_type'(x));
      write_reg(REG_ROT_Y, coord_type'(y));
      write_reg(REG_ROT_Z, coord_type'(z));
      write_reg(REG_SHIFT_X, sx);
      write_reg(REG_SHIFT_Y, sy);
      write_reg(REG_SHIFT_Z, sz);
      quat_w   = w;
      quat_x   = x;
      quat_y   = y;
      quat_z   = z;
      offset_x = sx;
      offset_y = sy;
      offset_z = sz;
      settings_used++;
   endtask

   task automatic pick_rotation(output quat_type w, output quat_type x,
                                output quat_type y, output quat_type z);
      quat_type q[4];
      int axis;
      q = '{default: '0};
      axis = $urandom_range(1, 3);
      case ($urandom_range(0, 5))
         0: q[0] = ROT_ONE;
         1: begin
            q[0]    = 16'sd11585;
            q[axis] = $urandom_range(0, 1) ? -16'sd11585 : 16'sd11585;
         end
         2: q[axis] = $urandom_range(0, 1) ? -ROT_ONE : ROT_ONE;
         3: begin
            foreach (q[i])
               q[i] = $urandom_range(0, 1) ? -16'sd8192 : 16'sd8192;
         end
         4: begin
            foreach (q[i])
               q[i] = quat_type'(int'($urandom_range(0, 32768)) - 16384);
         end
         default: begin
            foreach (q[i])
               q[i] = quat_type'($urandom);
         end
      endcase
      w = q[0];
      x = q[1];
      y = q[2];
      z = q[3];
   endtask

   // Sampled on the falling edge so that the driver's work at the rising
   // edge has fully settled.
   task automatic wait_until_drained();
      @(negedge clock);
      while (coords_to_send.size() != 0 || req_bus.valid || pending_transforms.size() != 0)
         @(negedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic check_field(string name, logic signed [COORD_W-1:0] want,
                              logic signed [COORD_W-1:0] got);
      if (want !== got) begin
         $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
         mismatches++;
      end
   endtask

   // Driver: the prediction is made from the payload of each transfer.
   always @(posedge clock) begin : drive_req
      coord_item_type item;
      int pick;
      static int send_gap  = 0;
      static int no_gap_run = 0;
      if (reset) begin
         req_bus.valid <= 1'b0;
      end else begin
         if (req_bus.valid && req_bus.ready) begin
            pending_transforms.push_back(rigid_transform(req_bus.in_x, req_bus.in_y,
               req_bus.in_z, req_bus.is_direction, req_bus.use_inverse));
            items_sent++;
         end
         if (!req_bus.valid || req_bus.ready) begin
            if (send_gap > 0) begin
               send_gap--;
               req_bus.valid <= 1'b0;
            end else if (coords_to_send.size() != 0) begin
               item = coords_to_send.pop_front();
               req_bus.valid        <= 1'b1;
               req_bus.in_x         <= item.x;
               req_bus.in_y         <= item.y;
               req_bus.in_z         <= item.z;
               req_bus.is_direction <= item.dir;
               req_bus.use_inverse  <= item.inv;
               if (no_gap_run > 0) begin
                  no_gap_run--;
               end else begin
                  pick = $urandom_range(0, 99);
                  if (pick < 5)
                     no_gap_run = $urandom_range(20, 60);
                  else if (pick < 55)
                     send_gap = 0;
                  else if (pick < 90)
                     send_gap = $urandom_range(1, 3);
                  else
                     send_gap = $urandom_range(6, 25);
               end
            end else begin
               req_bus.valid <= 1'b0;
            end
         end
      end
   end

   // Monitor: checks each result transfer and applies random back-pressure.
   always @(posedge clock) begin : take_rsp
      transform_type want;
      int pick;
      static int stall_left = 0;
      static int calm_left  = 0;
      if (reset) begin
         rsp_bus.ready <= 1'b0;
      end else begin
         if (rsp_bus.valid && rsp_bus.ready) begin
            if (pending_transforms.size() == 0) begin
               $display("%0t: result with nothing expected, actual x=%0d y=%0d z=%0d clipped=%0d",
                        $time, rsp_bus.out_x, rsp_bus.out_y, rsp_bus.out_z, rsp_bus.clipped);
               mismatches++;
            end else begin
               want = pending_transforms.pop_front();
               check_field("out_x", want.x, rsp_bus.out_x);
               check_field("out_y", want.y, rsp_bus.out_y);
               check_field("out_z", want.z, rsp_bus.out_z);
               check_field("clipped", want.clipped, rsp_bus.clipped);
               if (want.clipped)
                  results_clipped++;
            end
            results_checked++;
         end
         if (hold_off) begin
            rsp_bus.ready <= 1'b0;
         end else if (stall_left > 0) begin
            stall_left--;
            rsp_bus.ready <= 1'b0;
         end else begin
            rsp_bus.ready <= 1'b1;
            if (calm_left > 0) begin
               calm_left--;
            end else begin
               pick = $urandom_range(0, 99);
               if (pick < 3)
                  calm_left = $urandom_range(30, 80);
               else if (pick < 20)
                  stall_left = $urandom_range(1, 3);
               else if (pick < 24)
                  stall_left = $urandom_range(8, 30);
            end
         end
      end
   end

   // One long hold-off on the result side, so the pipeline fills and the
   // input side has to stall while items keep being offered.
   initial begin : long_hold
      wait (results_checked >= 300);
      @(posedge clock);
      hold_off <= 1'b1;
      repeat (HOLD_CYCLES) @(posedge clock);
      hold_off <= 1'b0;
   end

   initial begin : watchdog
      repeat (LIMIT_CYCLES) @(posedge clock);
      $display("quaternion_rigid_transform verification failed");
      $finish;
   end

   initial begin : stimulus
      quat_type w, x, y, z;
      req_bus.valid        = 1'b0;
      req_bus.in_x         = '0;
      req_bus.in_y         = '0;
      req_bus.in_z         = '0;
      req_bus.is_direction = 1'b0;
      req_bus.use_inverse  = 1'b0;
      rsp_bus.ready        = 1'b0;
      csr_wen              = 1'b0;
      csr_index            = REG_ROT_W;
      csr_wdata            = '0;
      repeat (4) @(posedge clock);
      reset <= 1'b0;

      // Identity transform out of reset, at the coordinate extremes.
      queue_item('0, '0, '0, 1'b0, 1'b0);
      queue_item(COORD_MAX, COORD_MIN, '1, 1'b0, 1'b0);
      queue_item(COORD_MIN, COORD_MAX, 32'sd1, 1'b1, 1'b0);
      queue_item(COORD_MAX, COORD_MAX, COORD_MAX, 1'b0, 1'b1);
      queue_item(COORD_MIN, COORD_MIN, COORD_MIN, 1'b1, 1'b1);
      wait_until_drained();

      // Quarter turn about z with extreme translations: saturation, and an
      // inverse point whose difference with the translation needs 33 bits.
      set_transform(16'sd11585, '0, '0, 16'sd11585, COORD_MAX, COORD_MIN, 32'sh0001_8000);
      queue_item(32'sh0001_0000, '0, '0, 1'b0, 1'b0);
      queue_item(32'sh0001_0000, 32'sh0002_0000, 32'sh0003_0000, 1'b1, 1'b0);
      queue_item(COORD_MAX, COORD_MAX, '0, 1'b0, 1'b0);
      queue_item(COORD_MIN, COORD_MAX, COORD_MIN, 1'b0, 1'b1);
      queue_item(COORD_MIN, COORD_MIN, 32'sd5, 1'b0, 1'b1);
      queue_item(32'sd123, -32'sd456, 32'sd789, 1'b1, 1'b1);
      wait_until_drained();

      // Non-unit quaternion with the most negative component values.
      set_transform(-16'sd32768, -16'sd32768, 16'sd32767, -16'sd32768, COORD_MIN, COORD_MAX, '1);
      queue_item(COORD_MAX, COORD_MIN, COORD_MAX, 1'b0, 1'b0);
      queue_item(COORD_MAX, COORD_MIN, COORD_MAX, 1'b1, 1'b0);
      queue_item(COORD_MAX, COORD_MIN, COORD_MAX, 1'b0, 1'b1);
      queue_item(COORD_MAX, COORD_MIN, COORD_MAX, 1'b1, 1'b1);
      queue_item(32'sd1, -32'sd1, 32'sd32767, 1'b0, 1'b0);
      queue_item('0, '0, '0, 1'b0, 1'b1);
      wait_until_drained();

      for (int ph = 0; ph < RANDOM_PHASES; ph++) begin
         if (ph == RANDOM_PHASES - 1) begin
            set_transform(16'sd32767, -16'sd32768, 16'sd16384, -16'sd16384,
                          COORD_MAX, COORD_MIN, COORD_MAX);
         end else begin
            pick_rotation(w, x, y, z);
            set_transform(w, x, y, z, rand_coord(), rand_coord(), rand_coord());
         end
         repeat (ITEMS_PER_PHASE)
            queue_item(rand_coord(), rand_coord(), rand_coord(),
                       1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)));
         wait_until_drained();
      end

      $display("Sent %0d coordinates and checked %0d results, %0d of them saturated,",
               items_sent, results_checked, results_clipped);
      $display("over %0d transform settings with points and vectors in both directions.",
               settings_used);
      if (mismatches == 0)
         $display("quaternion_rigid_transform verification clean");
      else
         $display("quaternion_rigid_transform verification failed");
      $finish;
   end

endmodule
